// File: sv/sha512_pkg.sv
// shared types, constants and round functions of the sha-512 engine
package sha512_pkg;

  typedef enum logic [1:0] {
    PUT_NONE,
    PUT_DATA,
    PUT_PAD,
    PUT_ZERO
  } put_op_e;

  typedef struct packed {
    logic       load;
    put_op_e    put_op;
    logic       len_wr;
    logic       comp_init;
    logic       round;
    logic       fold;
    logic       reinit;
    logic [2:0] idx;
  } sha512_cmd_t;

  typedef struct packed {
    logic       cnt_zero;
    logic       last;
    logic       put_full;
    logic [6:0] fill;
    logic       round_last;
  } sha512_sts_t;

  localparam logic [6:0] LenStart   = 7'd112;
  localparam logic [6:0] LenPos     = 7'd120;
  localparam logic [6:0] Rounds     = 7'd80;
  localparam logic [7:0] PadByte    = 8'h80;

  localparam logic [63:0] Iv [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_s0(input logic [63:0] x);
    big_s0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_s1(input logic [63:0] x);
    big_s1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_s0(input logic [63:0] x);
    small_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_s1(input logic [63:0] x);
    small_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

// File: sv/sha512_dp.sv
// sha-512 datapath: block store, byte packing, round logic and chaining value
module sha512_dp import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha512_cmd_t cmd_i,
  input  logic [63:0] word_i,
  input  logic [3:0]  count_i,
  input  logic        last_i,
  output sha512_sts_t sts_o,
  output logic [63:0] digest_o
);

  logic [63:0] store_q [16];
  logic [63:0] chain_q [8];
  logic [63:0] wv_q    [8];
  logic [63:0] pend_q;
  logic [3:0]  cnt_q;
  logic        last_q;
  logic [6:0]  fill_q;
  logic [63:0] len_q;
  logic [6:0]  rnd_q;

  logic [2:0]  off;
  logic [3:0]  wk;
  logic [3:0]  room;
  logic [3:0]  n;
  logic [63:0] src;
  logic [3:0]  end_b;
  logic [63:0] mask;
  logic [63:0] merged;
  logic [7:0]  fill_sum;
  logic [63:0] w_new;
  logic [63:0] t1;
  logic [63:0] t2;

  assign off  = fill_q[2:0];
  assign wk   = fill_q[6:3];
  assign room = 4'd8 - {1'b0, off};

  always_comb begin
    unique case (cmd_i.put_op)
      PUT_DATA: begin
        n   = (cnt_q < room) ? cnt_q : room;
        src = pend_q;
      end
      PUT_PAD: begin
        n   = 4'd1;
        src = {PadByte, 56'd0};
      end
      PUT_ZERO: begin
        n   = room;
        src = '0;
      end
      default: begin
        n   = 4'd0;
        src = '0;
      end
    endcase
  end

  assign end_b    = {1'b0, off} + n;
  assign mask     = ({64{1'b1}} >> {off, 3'b000}) & ~({64{1'b1}} >> {end_b, 3'b000});
  assign merged   = (store_q[wk] & ~mask) | ((src >> {off, 3'b000}) & mask);
  assign fill_sum = {1'b0, fill_q} + {4'd0, n};

  assign w_new = small_s1(store_q[14]) + store_q[9] + small_s0(store_q[1]) + store_q[0];
  assign t1 = wv_q[7] + big_s1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
            + RoundK[rnd_q] + store_q[0];
  assign t2 = big_s0(wv_q[0])
            + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

  // payload storage, working variables and pending input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.put_op != PUT_NONE) begin
      store_q[wk] <= merged;
    end else if (cmd_i.len_wr) begin
      store_q[15] <= len_q;
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) store_q[i] <= store_q[i+1];
      store_q[15] <= w_new;
    end
    if (cmd_i.comp_init) begin
      for (int i = 0; i < 8; i++) wv_q[i] <= chain_q[i];
    end else if (cmd_i.round) begin
      for (int i = 1; i < 8; i++) wv_q[i] <= wv_q[i-1];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[0] <= t1 + t2;
    end
    if (cmd_i.load) begin
      pend_q <= word_i;
      last_q <= last_i;
    end else if (cmd_i.put_op == PUT_DATA) begin
      pend_q <= pend_q << {n, 3'b000};
    end
  end

  // control-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= Iv[i];
      cnt_q  <= '0;
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= count_i[3] ? 4'd8 : count_i;
      end else if (cmd_i.put_op == PUT_DATA) begin
        cnt_q <= cnt_q - n;
        len_q <= len_q + {57'd0, n, 3'b000};
      end
      if (cmd_i.put_op != PUT_NONE) begin
        fill_q <= fill_sum[6:0];
      end else if (cmd_i.len_wr || cmd_i.reinit) begin
        fill_q <= '0;
      end
      if (cmd_i.comp_init || cmd_i.fold) begin
        rnd_q <= '0;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 7'd1;
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
      end else if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= Iv[i];
        len_q <= '0;
      end
    end
  end

  assign sts_o.cnt_zero   = (cnt_q == 4'd0);
  assign sts_o.last       = last_q;
  assign sts_o.put_full   = fill_sum[7];
  assign sts_o.fill       = fill_q;
  assign sts_o.round_last = (rnd_q == Rounds - 7'd1);
  assign digest_o         = chain_q[cmd_i.idx];

endmodule

// File: sv/sha512_ctrl.sv
// sha-512 sequencer: word loading, padding, compression and digest readout
module sha512_ctrl import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  sha512_sts_t sts_i,
  output sha512_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_PAD,
    S_PADZ,
    S_LEN,
    S_COMP,
    S_FOLD,
    S_OUT
  } state_e;

  state_e     state_q, state_d, ret_q, ret_d;
  logic       wrap_q, wrap_d;
  logic [2:0] idx_q, idx_d;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    wrap_d      = wrap_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PUT;
        end
      end
      S_PUT: begin
        if (sts_i.cnt_zero) begin
          state_d = sts_i.last ? S_PAD : S_IDLE;
        end else begin
          cmd_o.put_op = PUT_DATA;
          if (sts_i.put_full) begin
            cmd_o.comp_init = 1'b1;
            ret_d           = S_PUT;
            state_d         = S_COMP;
          end
        end
      end
      S_PAD: begin
        cmd_o.put_op = PUT_PAD;
        // no room for the length: zero out to the block end first
        wrap_d = (sts_i.fill >= LenStart) && !sts_i.put_full;
        if (sts_i.put_full) begin
          cmd_o.comp_init = 1'b1;
          ret_d           = S_PADZ;
          state_d         = S_COMP;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PADZ: begin
        if (!wrap_q && sts_i.fill == LenPos) begin
          state_d = S_LEN;
        end else begin
          cmd_o.put_op = PUT_ZERO;
          if (sts_i.put_full) begin
            wrap_d          = 1'b0;
            cmd_o.comp_init = 1'b1;
            ret_d           = S_PADZ;
            state_d         = S_COMP;
          end
        end
      end
      S_LEN: begin
        cmd_o.len_wr    = 1'b1;
        cmd_o.comp_init = 1'b1;
        ret_d           = S_OUT;
        state_d         = S_COMP;
      end
      S_COMP: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) state_d = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ret_q;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      wrap_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      wrap_q  <= wrap_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// File: sv/sha512_hash_engine_unit.sv
// sha-512 engine: takes a message as 64-bit big-endian words with a byte count
// and a last flag, and returns the 512-bit digest as eight 64-bit words, H0
// first. Each word is loaded, packed into the 128-byte block store (in two
// steps when it straddles a store word or a block boundary) and then seen to
// run out of bytes; each full block runs 80 rounds, one per cycle, on a single
// shared round unit, and the result is then folded into the chaining value.
// After the last word come the pad byte, the zero fill (one store word per
// cycle between compressions), the fill check and the length, with one or two
// more compressions; then the eight digest words are offered one per cycle
// while m_axis_tready is high. The engine works on one word at a time:
// s_axis_tready is high only while it is waiting for the next word. Counts
// above eight are taken as eight; a zero count without tlast is ignored, with
// tlast it ends the message (an empty message is legal). The length field is
// the bit count modulo 2^64, upper half zero
module sha512_hash_engine_unit import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // message_word
  input  logic [3:0]  s_axis_tuser,   // valid_bytes
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // digest_index
  output logic        m_axis_tlast    // digest_done
);

  sha512_cmd_t cmd;
  sha512_sts_t sts;

  // sequencer
  sha512_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // block store, rounds and chaining value
  sha512_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .word_i   (s_axis_tdata),
    .count_i  (s_axis_tuser),
    .last_i   (s_axis_tlast),
    .sts_o    (sts),
    .digest_o (m_axis_tdata)
  );

  // digest word position comes straight from the readout index
  assign m_axis_tuser = cmd.idx;
  assign m_axis_tlast = m_axis_tvalid && (cmd.idx == 3'd7);

`ifndef ASSERT_OFF
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during readout");

  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tlast |-> (m_axis_tuser == 3'd7)) else $error("digest end on wrong word");

  a_back_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after digest");

  a_busy_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("took two words");
`endif

endmodule
